@@ src/fbpa_pkg.sv @@
// Shared types and constants for the fixed block pool allocator.
// Used by the config registers, link memory, free FIFO and top level.
// No dependencies.
package fbpa_pkg;

  // Pool geometry
  localparam int unsigned MAX_BLOCKS = 256;
  localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned LINK_W     = IDX_W + 1;
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0]  MIN_COUNT = CNT_W'(2);
  localparam logic [CNT_W-1:0]  MAX_COUNT = CNT_W'(MAX_BLOCKS);

  // Register field widths
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned SIZE_W  = 25;
  localparam int unsigned PADDR_W = 4;

  // Register map, word index
  localparam logic [1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [1:0] REG_BLOCK_SIZE  = 2'd1;
  localparam logic [1:0] REG_BLOCK_COUNT = 2'd2;
  localparam logic [1:0] REG_USE_QUEUE   = 2'd3;

  // Register reset values
  localparam logic [DATA_W-1:0] RST_POOL_BASE   = 32'd0;
  localparam logic [SIZE_W-1:0] RST_BLOCK_SIZE  = 25'd64;
  localparam logic [CNT_W-1:0]  RST_BLOCK_COUNT = 9'd256;
  localparam logic              RST_USE_QUEUE   = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC_AUTO  = 2'd0,
    OP_ALLOC_INDEX = 2'd1,
    OP_FREE        = 2'd2,
    OP_INIT        = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_USED     = 3'd3,
    ST_NOT_USED = 3'd4,
    ST_MODE     = 3'd5
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] pool_base;
    logic [SIZE_W-1:0] block_size;
    logic [CNT_W-1:0]  block_count;
    logic              use_queue;
  } cfg_t;

  // Link memory write ports and shared read address
  typedef struct packed {
    logic              next_we;
    logic [IDX_W-1:0]  next_addr;
    logic [LINK_W-1:0] next_data;
    logic              prev_we;
    logic [IDX_W-1:0]  prev_addr;
    logic [LINK_W-1:0] prev_data;
    logic [IDX_W-1:0]  rd_addr;
  } link_ctrl_t;

  typedef struct packed {
    logic [LINK_W-1:0] next_link;
    logic [LINK_W-1:0] prev_link;
  } link_rd_t;

  // Free FIFO commands
  typedef struct packed {
    logic             clear;
    logic             fill_we;
    logic [IDX_W-1:0] fill_addr;
    logic             set_level;
    logic [CNT_W-1:0] level;
    logic             pop;
    logic             push;
    logic [IDX_W-1:0] push_data;
  } fifo_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] fill;
    logic [IDX_W-1:0] head_data;
  } fifo_stat_t;

endpackage

@@ src/fbpa_cfg_regs.sv @@
// APB-style configuration registers of the block pool allocator.
// Depends on fbpa_pkg for the register map, widths and reset values.
module fbpa_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fbpa_pkg::PADDR_W-1:0] paddr,
  input  logic [fbpa_pkg::DATA_W-1:0]  pwdata,
  output logic [fbpa_pkg::DATA_W-1:0]  prdata,
  output fbpa_pkg::cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  // Write on the access phase of a write transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pool_base   <= fbpa_pkg::RST_POOL_BASE;
      cfg.block_size  <= fbpa_pkg::RST_BLOCK_SIZE;
      cfg.block_count <= fbpa_pkg::RST_BLOCK_COUNT;
      cfg.use_queue   <= fbpa_pkg::RST_USE_QUEUE;
    end else if (wr_en) begin
      unique case (reg_sel)
        fbpa_pkg::REG_POOL_BASE:   cfg.pool_base   <= pwdata;
        fbpa_pkg::REG_BLOCK_SIZE:  cfg.block_size  <= pwdata[fbpa_pkg::SIZE_W-1:0];
        fbpa_pkg::REG_BLOCK_COUNT: cfg.block_count <= pwdata[fbpa_pkg::CNT_W-1:0];
        fbpa_pkg::REG_USE_QUEUE:   cfg.use_queue   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back, zero extended
  always_comb begin
    unique case (reg_sel)
      fbpa_pkg::REG_POOL_BASE:   prdata = cfg.pool_base;
      fbpa_pkg::REG_BLOCK_SIZE:  prdata = {7'd0, cfg.block_size};
      fbpa_pkg::REG_BLOCK_COUNT: prdata = {23'd0, cfg.block_count};
      fbpa_pkg::REG_USE_QUEUE:   prdata = {31'd0, cfg.use_queue};
      default:                   prdata = '0;
    endcase
  end

endmodule

@@ src/fbpa_link_mem.sv @@
// Next and previous link memories of the used-block list.
// One write port per array, one shared read address with registered read data.
// Depends on fbpa_pkg for the link types.
module fbpa_link_mem (
  input  logic                 clk,
  input  fbpa_pkg::link_ctrl_t ctrl,
  output fbpa_pkg::link_rd_t   rd
);

  logic [fbpa_pkg::LINK_W-1:0] next_mem [fbpa_pkg::MAX_BLOCKS];
  logic [fbpa_pkg::LINK_W-1:0] prev_mem [fbpa_pkg::MAX_BLOCKS];

  // Write links, register both links of the addressed block
  always_ff @(posedge clk) begin
    if (ctrl.next_we) begin
      next_mem[ctrl.next_addr] <= ctrl.next_data;
    end
    if (ctrl.prev_we) begin
      prev_mem[ctrl.prev_addr] <= ctrl.prev_data;
    end
    rd.next_link <= next_mem[ctrl.rd_addr];
    rd.prev_link <= prev_mem[ctrl.rd_addr];
  end

endmodule

@@ src/fbpa_free_fifo.sv @@
// Free-index FIFO: a circular memory of block indices with read and
// write pointers and a fill level. Depends on fbpa_pkg.
module fbpa_free_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  fbpa_pkg::fifo_ctrl_t ctrl,
  output fbpa_pkg::fifo_stat_t stat
);

  logic [fbpa_pkg::IDX_W-1:0] mem [fbpa_pkg::MAX_BLOCKS];
  logic [fbpa_pkg::IDX_W-1:0] rd_ptr;
  logic [fbpa_pkg::IDX_W-1:0] wr_ptr;
  logic [fbpa_pkg::CNT_W-1:0] fill;
  logic [fbpa_pkg::IDX_W-1:0] rd_data;

  // Write the initial sweep or a pushed index, register the head entry
  always_ff @(posedge clk) begin
    if (ctrl.fill_we) begin
      mem[ctrl.fill_addr] <= ctrl.fill_addr;
    end else if (ctrl.push) begin
      mem[wr_ptr] <= ctrl.push_data;
    end
    rd_data <= mem[rd_ptr];
  end

  // Pointers wrap naturally at MAX_BLOCKS entries
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else if (ctrl.set_level) begin
      wr_ptr <= ctrl.level[fbpa_pkg::IDX_W-1:0];
      fill   <= ctrl.level;
    end else if (ctrl.pop) begin
      rd_ptr <= rd_ptr + 1'b1;
      fill   <= fill - 1'b1;
    end else if (ctrl.push) begin
      wr_ptr <= wr_ptr + 1'b1;
      fill   <= fill + 1'b1;
    end
  end

  assign stat.fill      = fill;
  assign stat.head_data = rd_data;

endmodule

@@ src/fixed_block_pool_allocator.sv @@
// Fixed-size block pool allocator: top level with the item sequencer.
// Instantiates fbpa_cfg_regs, fbpa_link_mem and fbpa_free_fifo; uses fbpa_pkg.
//
// Input channel (in_valid/in_stall, operation, block_index) takes one item at a
// time; output channel (out_valid/out_stall) returns one result per item. The
// APB port sets pool_base, block_size, block_count and use_queue; write it only
// while no item is in flight. The result is presented in the same cycle in which
// the next item can be taken. The sequencer steps the link memories one write per
// array per cycle; the FIFO, link and used-flag reads and the multiply for the
// address are registered; the initialize sweep clears one used flag and, in queue
// mode, writes one FIFO entry per cycle.
// Results land in an output register, so a stalled receiver does not stop the
// next item from being taken; the sequencer only waits in its final step while
// that register is still held.
// Reset (synchronous, rst high) empties the list and FIFO and restores register
// defaults; then in_stall stays high while the clearing pass clears the used flags.
module fixed_block_pool_allocator (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fbpa_pkg::PADDR_W-1:0] paddr,
  input  logic [fbpa_pkg::DATA_W-1:0]  pwdata,
  output logic [fbpa_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  // Input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   operation,
  input  logic [7:0]                   block_index,
  // Output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   status,
  output logic [7:0]                   result_index,
  output logic [31:0]                  block_address,
  output logic [8:0]                   used_total,
  output logic [8:0]                   list_head,
  output logic [8:0]                   list_tail
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DISPATCH = 10'b0000000010,
    S_POP      = 10'b0000000100,
    S_POP_CHK  = 10'b0000001000,
    S_APPEND1  = 10'b0000010000,
    S_APPEND2  = 10'b0000100000,
    S_UNLINK   = 10'b0001000000,
    S_FILL     = 10'b0010000000,
    S_RESULT   = 10'b0100000000,
    S_CLEAR    = 10'b1000000000
  } state_t;

  state_t                      state;
  state_t                      state_next;
  fbpa_pkg::cfg_t              cfg;
  fbpa_pkg::link_ctrl_t        link_ctrl;
  fbpa_pkg::link_rd_t          link_rd;
  fbpa_pkg::fifo_ctrl_t        fifo_ctrl;
  fbpa_pkg::fifo_stat_t        fifo_stat;

  fbpa_pkg::op_t               op_reg;
  fbpa_pkg::status_t           item_status;
  fbpa_pkg::status_t           disp_status;
  logic [fbpa_pkg::IDX_W-1:0]  idx_reg;
  logic [fbpa_pkg::CNT_W-1:0]  fill_cnt;
  logic [fbpa_pkg::DATA_W-1:0] prod;

  logic                            used_mem [fbpa_pkg::MAX_BLOCKS];
  logic                            used_rd;
  logic [fbpa_pkg::IDX_W-1:0]      used_rd_addr;
  logic [fbpa_pkg::LINK_W-1:0]     used_head;
  logic [fbpa_pkg::LINK_W-1:0]     used_tail;
  logic [fbpa_pkg::CNT_W-1:0]      used_count;
  logic [fbpa_pkg::CNT_W-1:0]      live_count;
  logic                            live_queue;
  logic [fbpa_pkg::CNT_W-1:0]      count_clamped;

  logic in_accept;
  logic out_load;
  logic idx_in_range;
  logic idx_used;
  logic fill_last;
  logic clear_last;
  logic [fbpa_pkg::LINK_W-1:0] unl_prev;
  logic [fbpa_pkg::LINK_W-1:0] unl_next;

  fbpa_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  fbpa_link_mem u_links (
    .clk  (clk),
    .ctrl (link_ctrl),
    .rd   (link_rd)
  );

  fbpa_free_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .ctrl (fifo_ctrl),
    .stat (fifo_stat)
  );

  assign pready    = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && (state == S_IDLE);
  assign out_load  = (state == S_RESULT) && (!out_valid || !out_stall);

  assign idx_in_range = ({1'b0, idx_reg} < live_count);
  assign idx_used     = used_rd;
  assign fill_last    = (fill_cnt == live_count - 1'b1);
  assign clear_last   = (fill_cnt == fbpa_pkg::MAX_COUNT - 1'b1);
  assign unl_prev     = link_rd.prev_link;
  assign unl_next     = link_rd.next_link;

  // Saturate the programmed count to the pool limits
  always_comb begin
    if (cfg.block_count > fbpa_pkg::MAX_COUNT) begin
      count_clamped = fbpa_pkg::MAX_COUNT;
    end else if (cfg.block_count < fbpa_pkg::MIN_COUNT) begin
      count_clamped = fbpa_pkg::MIN_COUNT;
    end else begin
      count_clamped = cfg.block_count;
    end
  end

  // Check the item against mode, FIFO fill, range and used flag
  always_comb begin
    disp_status = fbpa_pkg::ST_OK;
    unique case (op_reg)
      fbpa_pkg::OP_ALLOC_AUTO: begin
        if (!live_queue) begin
          disp_status = fbpa_pkg::ST_MODE;
        end else if (fifo_stat.fill == '0) begin
          disp_status = fbpa_pkg::ST_EMPTY;
        end
      end
      fbpa_pkg::OP_ALLOC_INDEX: begin
        if (live_queue) begin
          disp_status = fbpa_pkg::ST_MODE;
        end else if (!idx_in_range) begin
          disp_status = fbpa_pkg::ST_RANGE;
        end else if (idx_used) begin
          disp_status = fbpa_pkg::ST_USED;
        end
      end
      fbpa_pkg::OP_FREE: begin
        if (!idx_in_range) begin
          disp_status = fbpa_pkg::ST_RANGE;
        end else if (!idx_used) begin
          disp_status = fbpa_pkg::ST_NOT_USED;
        end
      end
      default: disp_status = fbpa_pkg::ST_OK;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (disp_status != fbpa_pkg::ST_OK) begin
          state_next = S_RESULT;
        end else begin
          unique case (op_reg)
            fbpa_pkg::OP_ALLOC_AUTO:  state_next = S_POP;
            fbpa_pkg::OP_ALLOC_INDEX: state_next = S_APPEND1;
            fbpa_pkg::OP_FREE:        state_next = S_UNLINK;
            default:                  state_next = S_FILL;
          endcase
        end
      end
      S_POP:     state_next = S_POP_CHK;
      S_POP_CHK: state_next = (idx_in_range && !idx_used) ? S_APPEND1 : S_RESULT;
      S_APPEND1: state_next = S_APPEND2;
      S_APPEND2: state_next = S_RESULT;
      S_UNLINK:  state_next = S_RESULT;
      S_FILL: begin
        if (fill_last) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Link memory accesses; reads always target the current block
  always_comb begin
    link_ctrl         = '0;
    link_ctrl.rd_addr = idx_reg;
    unique case (state)
      S_APPEND1: begin
        link_ctrl.prev_we   = 1'b1;
        link_ctrl.prev_addr = idx_reg;
        link_ctrl.prev_data = used_tail;
        link_ctrl.next_we   = 1'b1;
        link_ctrl.next_addr = idx_reg;
        link_ctrl.next_data = fbpa_pkg::NONE_LINK;
      end
      S_APPEND2: begin
        if (!used_tail[fbpa_pkg::IDX_W]) begin
          link_ctrl.next_we   = 1'b1;
          link_ctrl.next_addr = used_tail[fbpa_pkg::IDX_W-1:0];
          link_ctrl.next_data = {1'b0, idx_reg};
        end
      end
      S_UNLINK: begin
        if (!unl_prev[fbpa_pkg::IDX_W]) begin
          link_ctrl.next_we   = 1'b1;
          link_ctrl.next_addr = unl_prev[fbpa_pkg::IDX_W-1:0];
          link_ctrl.next_data = unl_next;
        end
        if (!unl_next[fbpa_pkg::IDX_W]) begin
          link_ctrl.prev_we   = 1'b1;
          link_ctrl.prev_addr = unl_next[fbpa_pkg::IDX_W-1:0];
          link_ctrl.prev_data = unl_prev;
        end
      end
      default: ;
    endcase
  end

  // Free FIFO commands
  always_comb begin
    fifo_ctrl = '0;
    unique case (state)
      S_DISPATCH: begin
        fifo_ctrl.clear = (op_reg == fbpa_pkg::OP_INIT);
      end
      S_FILL: begin
        fifo_ctrl.fill_we   = live_queue;
        fifo_ctrl.fill_addr = fill_cnt[fbpa_pkg::IDX_W-1:0];
        fifo_ctrl.set_level = live_queue && fill_last;
        fifo_ctrl.level     = live_count;
      end
      S_POP: begin
        fifo_ctrl.pop = 1'b1;
      end
      S_UNLINK: begin
        fifo_ctrl.push      = live_queue && (fifo_stat.fill < fbpa_pkg::MAX_COUNT);
        fifo_ctrl.push_data = idx_reg;
      end
      default: ;
    endcase
  end

  // Used-flag read address: the incoming block, the FIFO head, or the held block
  always_comb begin
    unique case (state)
      S_IDLE:  used_rd_addr = block_index;
      S_POP:   used_rd_addr = fifo_stat.head_data;
      default: used_rd_addr = idx_reg;
    endcase
  end

  // Used-flag memory: clear on sweeps, set on append, drop on unlink
  always_ff @(posedge clk) begin
    unique case (state)
      S_CLEAR:   used_mem[fill_cnt[fbpa_pkg::IDX_W-1:0]] <= 1'b0;
      S_FILL:    used_mem[fill_cnt[fbpa_pkg::IDX_W-1:0]] <= 1'b0;
      S_APPEND1: used_mem[idx_reg] <= 1'b1;
      S_UNLINK:  used_mem[idx_reg] <= 1'b0;
      default: ;
    endcase
    used_rd <= used_mem[used_rd_addr];
  end

  // Sweep counter for the clearing pass after reset and for initialize
  always_ff @(posedge clk) begin
    if (rst || (state == S_DISPATCH)) begin
      fill_cnt <= '0;
    end else if ((state == S_CLEAR) || (state == S_FILL)) begin
      fill_cnt <= fill_cnt + 1'b1;
    end
  end

  // Pool state: list ends, counts and latched mode
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      used_head  <= fbpa_pkg::NONE_LINK;
      used_tail  <= fbpa_pkg::NONE_LINK;
      used_count <= '0;
      live_count <= fbpa_pkg::MAX_COUNT;
      live_queue <= 1'b1;
    end else begin
      state <= state_next;
      unique case (state)
        S_DISPATCH: begin
          if (op_reg == fbpa_pkg::OP_INIT) begin
            used_head  <= fbpa_pkg::NONE_LINK;
            used_tail  <= fbpa_pkg::NONE_LINK;
            used_count <= '0;
            live_count <= count_clamped;
            live_queue <= cfg.use_queue;
          end
        end
        S_APPEND1: begin
          used_count <= used_count + 1'b1;
        end
        S_APPEND2: begin
          if (used_tail[fbpa_pkg::IDX_W]) used_head <= {1'b0, idx_reg};
          used_tail <= {1'b0, idx_reg};
        end
        S_UNLINK: begin
          if (unl_prev[fbpa_pkg::IDX_W]) used_head <= unl_next;
          if (unl_next[fbpa_pkg::IDX_W]) used_tail <= unl_prev;
          if (used_count != '0) used_count <= used_count - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Item registers and the address multiply
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_reg      <= fbpa_pkg::op_t'(operation);
      item_status <= fbpa_pkg::ST_OK;
      if ((fbpa_pkg::op_t'(operation) == fbpa_pkg::OP_ALLOC_AUTO) ||
          (fbpa_pkg::op_t'(operation) == fbpa_pkg::OP_INIT)) begin
        idx_reg <= '0;
      end else begin
        idx_reg <= block_index;
      end
    end
    if (state == S_DISPATCH) begin
      item_status <= disp_status;
    end
    if (state == S_POP) begin
      idx_reg <= fifo_stat.head_data;
    end
    prod <= {24'd0, idx_reg} * {7'd0, cfg.block_size};
  end

  // Output register: load the result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status        <= item_status;
      result_index  <= idx_reg;
      block_address <= (item_status == fbpa_pkg::ST_OK) ? (cfg.pool_base + prod) : '0;
      used_total    <= used_count;
      list_head     <= used_head;
      list_tail     <= used_tail;
    end
  end

  // List ends agree with the used count between items
  a_head_vs_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((used_head == fbpa_pkg::NONE_LINK) == (used_count == '0)))
    else $error("list head and used count disagree");

  a_head_vs_tail: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((used_head == fbpa_pkg::NONE_LINK) ==
                           (used_tail == fbpa_pkg::NONE_LINK)))
    else $error("list head and tail disagree on empty list");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= live_count)
    else $error("used count exceeds pool size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("new transaction taken while an item is in work");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && (state == S_IDLE)))
    else $error("result not presented after the final step");

endmodule

@@ bench/fbpa_result_checker.sv @@
// Result checker for the fixed block pool allocator: tracks the APB register writes,
// keeps a model of the pool and compares every result against it in order.
// Depends on fbpa_pkg for field widths, opcodes, status codes and register indexes.
module fbpa_result_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [fbpa_pkg::PADDR_W-1:0] paddr,
  input  logic [fbpa_pkg::DATA_W-1:0]  pwdata,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [1:0]                   operation,
  input  logic [7:0]                   block_index,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [2:0]                   status,
  input  logic [7:0]                   result_index,
  input  logic [31:0]                  block_address,
  input  logic [8:0]                   used_total,
  input  logic [8:0]                   list_head,
  input  logic [8:0]                   list_tail,
  output int unsigned                  fail_count,
  output int unsigned                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    fbpa_pkg::status_t           st;
    logic [fbpa_pkg::IDX_W-1:0]  idx;
    logic [31:0]                 addr;
    logic [fbpa_pkg::CNT_W-1:0]  used;
    logic [fbpa_pkg::LINK_W-1:0] head;
    logic [fbpa_pkg::LINK_W-1:0] tail;
  } pool_result_t;

  // Register copies
  logic [fbpa_pkg::DATA_W-1:0] cfg_base;
  logic [fbpa_pkg::SIZE_W-1:0] cfg_size;
  logic [fbpa_pkg::CNT_W-1:0]  cfg_count;
  logic                        cfg_queue;

  // Pool state
  logic                        block_used [fbpa_pkg::MAX_BLOCKS];
  logic [fbpa_pkg::LINK_W-1:0] next_of [fbpa_pkg::MAX_BLOCKS];
  logic [fbpa_pkg::LINK_W-1:0] prev_of [fbpa_pkg::MAX_BLOCKS];
  logic [fbpa_pkg::IDX_W-1:0]  fifo_mem [fbpa_pkg::MAX_BLOCKS];
  logic [fbpa_pkg::IDX_W-1:0]  rd_ptr;
  logic [fbpa_pkg::IDX_W-1:0]  wr_ptr;
  logic [fbpa_pkg::CNT_W-1:0]  fifo_fill;
  logic [fbpa_pkg::LINK_W-1:0] head;
  logic [fbpa_pkg::LINK_W-1:0] tail;
  logic [fbpa_pkg::CNT_W-1:0]  used_cnt;
  logic [fbpa_pkg::CNT_W-1:0]  live_cnt;
  logic                        live_queue;

  pool_result_t expected_results [$];
  int unsigned  mismatches;

  function automatic logic [fbpa_pkg::CNT_W-1:0] clamp_blocks(
      input logic [fbpa_pkg::CNT_W-1:0] c);
    if (c > fbpa_pkg::MAX_COUNT) return fbpa_pkg::MAX_COUNT;
    if (c < fbpa_pkg::MIN_COUNT) return fbpa_pkg::MIN_COUNT;
    return c;
  endfunction

  function automatic logic [31:0] block_addr(input logic [fbpa_pkg::IDX_W-1:0] b);
    return cfg_base + 32'(b) * 32'(cfg_size);
  endfunction

  task automatic clear_pool_state();
    for (int i = 0; i < fbpa_pkg::MAX_BLOCKS; i++) begin
      block_used[i] = 1'b0;
      next_of[i]    = fbpa_pkg::NONE_LINK;
      prev_of[i]    = fbpa_pkg::NONE_LINK;
      fifo_mem[i]   = '0;
    end
    rd_ptr    = '0;
    wr_ptr    = '0;
    fifo_fill = '0;
    head      = fbpa_pkg::NONE_LINK;
    tail      = fbpa_pkg::NONE_LINK;
    used_cnt  = '0;
  endtask

  // Append a block at the tail of the used list
  task automatic link_at_tail(input logic [fbpa_pkg::IDX_W-1:0] b);
    block_used[b] = 1'b1;
    prev_of[b]    = tail;
    next_of[b]    = fbpa_pkg::NONE_LINK;
    if (tail != fbpa_pkg::NONE_LINK) next_of[tail[fbpa_pkg::IDX_W-1:0]] = fbpa_pkg::LINK_W'(b);
    else head = fbpa_pkg::LINK_W'(b);
    tail     = fbpa_pkg::LINK_W'(b);
    used_cnt = used_cnt + 1'b1;
  endtask

  // Advance the pool model by one transaction and build its result
  task automatic apply_pool_op(input fbpa_pkg::op_t op,
                               input logic [fbpa_pkg::IDX_W-1:0] bi,
                               output pool_result_t res);
    logic [fbpa_pkg::IDX_W-1:0]  b;
    logic [fbpa_pkg::LINK_W-1:0] p;
    logic [fbpa_pkg::LINK_W-1:0] n;
    res.st   = fbpa_pkg::ST_OK;
    res.idx  = '0;
    res.addr = '0;
    case (op)
      fbpa_pkg::OP_INIT: begin
        clear_pool_state();
        live_cnt   = clamp_blocks(cfg_count);
        live_queue = cfg_queue;
        if (live_queue) begin
          for (int i = 0; i < live_cnt; i++) fifo_mem[i] = fbpa_pkg::IDX_W'(i);
          fifo_fill = live_cnt;
          wr_ptr    = fbpa_pkg::IDX_W'(live_cnt);
        end
        res.addr = cfg_base;
      end
      fbpa_pkg::OP_ALLOC_AUTO: begin
        if (!live_queue) res.st = fbpa_pkg::ST_MODE;
        else if (fifo_fill == 0) res.st = fbpa_pkg::ST_EMPTY;
        else begin
          b         = fifo_mem[rd_ptr];
          rd_ptr    = rd_ptr + 1'b1;
          fifo_fill = fifo_fill - 1'b1;
          if (fbpa_pkg::CNT_W'(b) < live_cnt && !block_used[b]) link_at_tail(b);
          res.idx  = b;
          res.addr = block_addr(b);
        end
      end
      fbpa_pkg::OP_ALLOC_INDEX: begin
        res.idx = bi;
        if (live_queue) res.st = fbpa_pkg::ST_MODE;
        else if (fbpa_pkg::CNT_W'(bi) >= live_cnt) res.st = fbpa_pkg::ST_RANGE;
        else if (block_used[bi]) res.st = fbpa_pkg::ST_USED;
        else begin
          link_at_tail(bi);
          res.addr = block_addr(bi);
        end
      end
      default: begin
        res.idx = bi;
        if (fbpa_pkg::CNT_W'(bi) >= live_cnt) res.st = fbpa_pkg::ST_RANGE;
        else if (!block_used[bi]) res.st = fbpa_pkg::ST_NOT_USED;
        else begin
          // unlink from anywhere in the list
          p = prev_of[bi];
          n = next_of[bi];
          if (p != fbpa_pkg::NONE_LINK) next_of[p[fbpa_pkg::IDX_W-1:0]] = n;
          else head = n;
          if (n != fbpa_pkg::NONE_LINK) prev_of[n[fbpa_pkg::IDX_W-1:0]] = p;
          else tail = p;
          prev_of[bi]    = fbpa_pkg::NONE_LINK;
          next_of[bi]    = fbpa_pkg::NONE_LINK;
          block_used[bi] = 1'b0;
          if (used_cnt > 0) used_cnt = used_cnt - 1'b1;
          // return the index to the free FIFO
          if (live_queue && fifo_fill < fbpa_pkg::MAX_COUNT) begin
            fifo_mem[wr_ptr] = bi;
            wr_ptr           = wr_ptr + 1'b1;
            fifo_fill        = fifo_fill + 1'b1;
          end
          res.addr = block_addr(bi);
        end
      end
    endcase
    res.used = used_cnt;
    res.head = head;
    res.tail = tail;
  endtask

  always @(posedge clk) begin : watch
    pool_result_t predicted;
    pool_result_t observed;
    pool_result_t oldest;
    if (rst) begin
      cfg_base   = fbpa_pkg::RST_POOL_BASE;
      cfg_size   = fbpa_pkg::RST_BLOCK_SIZE;
      cfg_count  = fbpa_pkg::RST_BLOCK_COUNT;
      cfg_queue  = fbpa_pkg::RST_USE_QUEUE;
      clear_pool_state();
      live_cnt   = clamp_blocks(fbpa_pkg::RST_BLOCK_COUNT);
      live_queue = 1'b1;
      expected_results.delete();
      mismatches = 0;
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          fbpa_pkg::REG_POOL_BASE:   cfg_base  = pwdata;
          fbpa_pkg::REG_BLOCK_SIZE:  cfg_size  = pwdata[fbpa_pkg::SIZE_W-1:0];
          fbpa_pkg::REG_BLOCK_COUNT: cfg_count = pwdata[fbpa_pkg::CNT_W-1:0];
          fbpa_pkg::REG_USE_QUEUE:   cfg_queue = pwdata[0];
          default: ;
        endcase
      end

      // Predict each accepted input transaction
      if (in_valid && !in_stall) begin
        apply_pool_op(fbpa_pkg::op_t'(operation), block_index, predicted);
        expected_results.push_back(predicted);
      end

      // Compare each accepted output transaction with the oldest prediction
      if (out_valid && !out_stall) begin
        observed.st   = fbpa_pkg::status_t'(status);
        observed.idx  = result_index;
        observed.addr = block_address;
        observed.used = used_total;
        observed.head = list_head;
        observed.tail = list_tail;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing expected: status %0d index %0d",
                     $time, status, result_index);
        end else begin
          oldest = expected_results.pop_front();
          if (observed !== oldest) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch (exp/got) status %0d/%0d index %0d/%0d",
                        " addr %h/%h used %0d/%0d head %0d/%0d tail %0d/%0d"},
                       $time, oldest.st, observed.st, oldest.idx, observed.idx,
                       oldest.addr, observed.addr, oldest.used, observed.used,
                       oldest.head, observed.head, oldest.tail, observed.tail);
          end
        end
      end
    end
    fail_count  <= mismatches;
    outstanding <= expected_results.size();
  end

endmodule

@@ bench/fixed_block_pool_allocator_test.sv @@
// Top of the fixed block pool allocator bench: clock, reset, APB setup, stimulus
// and verdict. Instantiates fixed_block_pool_allocator and fbpa_result_checker;
// uses fbpa_pkg.
module fixed_block_pool_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                         clk         = 1'b0;
  logic                         rst         = 1'b1;
  logic                         psel        = 1'b0;
  logic                         penable     = 1'b0;
  logic                         pwrite      = 1'b0;
  logic [fbpa_pkg::PADDR_W-1:0] paddr       = '0;
  logic [fbpa_pkg::DATA_W-1:0]  pwdata      = '0;
  logic [fbpa_pkg::DATA_W-1:0]  prdata;
  logic                         pready;
  logic                         in_valid    = 1'b0;
  logic                         in_stall;
  logic [1:0]                   operation   = fbpa_pkg::OP_INIT;
  logic [7:0]                   block_index = '0;
  logic                         out_valid;
  logic                         out_stall   = 1'b0;
  logic [2:0]                   status;
  logic [7:0]                   result_index;
  logic [31:0]                  block_address;
  logic [8:0]                   used_total;
  logic [8:0]                   list_head;
  logic [8:0]                   list_tail;
  int unsigned                  fail_count;
  int unsigned                  outstanding;
  logic                         steady      = 1'b0;

  fixed_block_pool_allocator u_top (.*);

  fbpa_result_checker u_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the result side at random, except during the steady stretch
  always @(posedge clk) out_stall <= !steady && ($urandom_range(99) < 37);

  // Hold off, then present one transaction until it is taken
  task automatic send_item(input fbpa_pkg::op_t op, input logic [7:0] idx);
    if (!steady)
      while ($urandom_range(99) < 37) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid    <= 1'b1;
    operation   <= op;
    block_index <= idx;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every result is back and the block has settled
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] sel,
                           input logic [fbpa_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic configure_pool(input logic [31:0] base,
                                input logic [fbpa_pkg::SIZE_W-1:0] bsize,
                                input logic [fbpa_pkg::CNT_W-1:0] count,
                                input logic queue);
    drain_results();
    write_reg(fbpa_pkg::REG_POOL_BASE, base);
    write_reg(fbpa_pkg::REG_BLOCK_SIZE, fbpa_pkg::DATA_W'(bsize));
    write_reg(fbpa_pkg::REG_BLOCK_COUNT, fbpa_pkg::DATA_W'(count));
    write_reg(fbpa_pkg::REG_USE_QUEUE, fbpa_pkg::DATA_W'(queue));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Time limit on the whole run
  initial begin
    #(10_000_000);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned                 ph;
    int unsigned                 k;
    int unsigned                 roll;
    int unsigned                 bias;
    int unsigned                 eff;
    logic [fbpa_pkg::CNT_W-1:0]  count;
    logic                        queue;
    logic [31:0]                 base;
    logic [fbpa_pkg::SIZE_W-1:0] bsize;
    int unsigned                 count_set [8];

    count_set = '{2, 256, 5, 1, 300, 17, 64, 0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Before any init: empty FIFO, queue mode, nothing used
    send_item(fbpa_pkg::OP_ALLOC_AUTO, 8'd0);
    send_item(fbpa_pkg::OP_ALLOC_INDEX, 8'd3);
    send_item(fbpa_pkg::OP_FREE, 8'd255);
    // Default pool: allocate three, free middle, head, tail, then a free block
    send_item(fbpa_pkg::OP_INIT, 8'd0);
    send_item(fbpa_pkg::OP_ALLOC_AUTO, 8'd0);
    send_item(fbpa_pkg::OP_ALLOC_AUTO, 8'd0);
    send_item(fbpa_pkg::OP_ALLOC_AUTO, 8'd0);
    send_item(fbpa_pkg::OP_FREE, 8'd1);
    send_item(fbpa_pkg::OP_FREE, 8'd0);
    send_item(fbpa_pkg::OP_FREE, 8'd2);
    send_item(fbpa_pkg::OP_FREE, 8'd2);

    // Count below minimum, indexed mode, top address and a size of 2^24
    configure_pool(32'hFFFF_FFF0, 25'h100_0000, 9'd1, 1'b0);
    send_item(fbpa_pkg::OP_ALLOC_AUTO, 8'd0);
    send_item(fbpa_pkg::OP_INIT, 8'hFF);
    send_item(fbpa_pkg::OP_ALLOC_AUTO, 8'd0);
    send_item(fbpa_pkg::OP_ALLOC_INDEX, 8'd1);
    send_item(fbpa_pkg::OP_ALLOC_INDEX, 8'd0);
    send_item(fbpa_pkg::OP_ALLOC_INDEX, 8'd0);
    send_item(fbpa_pkg::OP_ALLOC_INDEX, 8'd2);
    send_item(fbpa_pkg::OP_ALLOC_INDEX, 8'd255);
    send_item(fbpa_pkg::OP_FREE, 8'd1);
    send_item(fbpa_pkg::OP_FREE, 8'd0);
    send_item(fbpa_pkg::OP_FREE, 8'd0);
    send_item(fbpa_pkg::OP_FREE, 8'd200);

    // Count above maximum, all-ones base, unit size
    configure_pool(32'hFFFF_FFFF, 25'd1, 9'd511, 1'b1);
    send_item(fbpa_pkg::OP_INIT, 8'd0);
    send_item(fbpa_pkg::OP_ALLOC_AUTO, 8'd0);
    send_item(fbpa_pkg::OP_ALLOC_INDEX, 8'd0);

    // Random phases, each opened by an init and mostly well-formed
    for (ph = 0; ph < 8; ph++) begin
      count = fbpa_pkg::CNT_W'(count_set[ph]);
      queue = (ph % 2 == 0);
      base  = (ph == 1) ? 32'd0 : (ph == 2) ? 32'hFFFF_FFFF : $urandom;
      case (ph % 4)
        0:       bsize = 25'd1;
        1:       bsize = 25'h100_0000;
        2:       bsize = fbpa_pkg::SIZE_W'($urandom_range(16777216, 1));
        default: bsize = fbpa_pkg::SIZE_W'($urandom_range(4096, 1));
      endcase
      configure_pool(base, bsize, count, queue);
      steady <= (ph == 5);
      eff  = (count < 2) ? 2 : (count > 256) ? 256 : count;
      bias = (eff == 256) ? 85 : $urandom_range(70, 40);
      send_item(fbpa_pkg::OP_INIT, 8'($urandom));
      for (k = 1; k < 244; k++) begin
        roll = $urandom_range(99);
        if (roll < 2) send_item(fbpa_pkg::OP_INIT, 8'($urandom));
        else if (roll < 8)
          send_item(fbpa_pkg::op_t'($urandom_range(2)), 8'($urandom_range(255)));
        else if ($urandom_range(99) < bias)
          send_item(queue ? fbpa_pkg::OP_ALLOC_AUTO : fbpa_pkg::OP_ALLOC_INDEX,
                    8'($urandom_range(eff - 1)));
        else send_item(fbpa_pkg::OP_FREE, 8'($urandom_range(eff - 1)));
      end
    end

    drain_results();
    if (fail_count == 0 && outstanding == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
